// ===== rtl/core/rvx_pkg.sv =====
package rvx_pkg;

    localparam int DATA_W        = 32;
    localparam int NUM_REGS_DEF  = 32;
    localparam int MEM_WORDS_DEF = 1024;

    typedef enum logic [3:0] {
        OP_MOVE  = 4'd0,
        OP_COPY  = 4'd1,
        OP_ADD   = 4'd2,
        OP_SUB   = 4'd3,
        OP_MUL   = 4'd4,
        OP_DIV   = 4'd5,
        OP_EQ    = 4'd6,
        OP_LT    = 4'd7,
        OP_LE    = 4'd8,
        OP_GT    = 4'd9,
        OP_GE    = 4'd10,
        OP_LOAD  = 4'd11,
        OP_STORE = 4'd12,
        OP_PRINT = 4'd13,
        OP_JZ    = 4'd14,
        OP_JMP   = 4'd15
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OPS,
        ST_DIV,
        ST_ADIV,
        ST_MEM,
        ST_LDW,
        ST_WB
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [4:0]         dest_reg;
        logic [DATA_W-1:0]  operand_value;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]  next_pc;
        logic               reg_written;
        logic [DATA_W-1:0]  result_value;
        logic               print_valid;
        logic               div_zero;
    } res_t;

    // divider handshake toward the sequencer
    typedef struct packed {
        logic               done;
        logic [DATA_W-1:0]  quo;
    } div_res_t;

endpackage

// ===== rtl/core/rvx_regfile.sv =====
module rvx_regfile
    import rvx_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF,
    localparam int RW = $clog2(NUM_REGS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RW-1:0]     rd_addr_a,
    input  logic [RW-1:0]     rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b,
    input  logic              wr_en,
    input  logic [RW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [DATA_W-1:0]   data_a_reg;
    logic [DATA_W-1:0]   data_b_reg;
    logic                va_reg;
    logic                vb_reg;

    // storage and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        data_a_reg <= mem[rd_addr_a];
        data_b_reg <= mem[rd_addr_b];
    end

    // per-entry valid bits; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            va_reg <= valid_reg[rd_addr_a];
            vb_reg <= valid_reg[rd_addr_b];
        end
    end

    assign rd_data_a = va_reg ? data_a_reg : '0;
    assign rd_data_b = vb_reg ? data_b_reg : '0;

endmodule

// ===== rtl/core/rvx_dmem.sv =====
module rvx_dmem
    import rvx_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF,
    localparam int MW = $clog2(MEM_WORDS)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [MW-1:0]     addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [MEM_WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    // single port, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rvx_divider.sv =====
module rvx_divider
    import rvx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output div_res_t          result
);

    localparam int CW = $clog2(DATA_W);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] quo_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] dvs_reg;
    logic [DATA_W-1:0] dvs_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
            rem_next = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign result.done = done_reg;
    assign result.quo  = quo_reg;

endmodule

// ===== rtl/core/register_vm_instruction_execute.sv =====
// Channel  Dir  Valid      Stall      Beat
// cmd      in   cmd_valid  cmd_stall  cmd_t: op, dest_reg, operand_value
// res      out  res_valid  res_stall  res_t: next_pc, reg_written, result_value,
//                                     print_valid, div_zero
// One instruction at a time: accept, register-file read, execute, write back.
// Load/store pass through the data memory port (ST_MEM, and ST_LDW for loads),
// a divide by a nonzero divisor waits on the bit-serial divider, and address
// folding (ST_ADIV) runs first when MEM_WORDS is not a power of two.
// After reset the data memory is cleared, one word a cycle, with cmd_stall
// high. A stalled result holds its register; the next beat is still taken
// and waits at write back until the output register frees.
module register_vm_instruction_execute
    import rvx_pkg::*;
#(
    parameter int NUM_REGS  = NUM_REGS_DEF,
    parameter int MEM_WORDS = MEM_WORDS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int RW = $clog2(NUM_REGS);
    localparam int MW = $clog2(MEM_WORDS);
    localparam bit MEM_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

    state_t            state_reg;
    state_t            state_next;
    op_t               op_reg;
    op_t               op_next;
    logic [RW-1:0]     rd_reg;
    logic [RW-1:0]     rd_next;
    logic [DATA_W-1:0] imm_reg;
    logic [DATA_W-1:0] imm_next;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] a_next;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic              wr_reg;
    logic              wr_next;
    logic              prn_reg;
    logic              prn_next;
    logic              dz_reg;
    logic              dz_next;
    logic [DATA_W-1:0] pc_reg;
    logic [DATA_W-1:0] pc_next;
    logic [DATA_W-1:0] npc_reg;
    logic [DATA_W-1:0] npc_next;
    logic [MW-1:0]     addr_reg;
    logic [MW-1:0]     addr_next;
    logic [DATA_W-1:0] fold_reg;
    logic [DATA_W-1:0] fold_next;
    logic [1:0]        fgrp_reg;
    logic [1:0]        fgrp_next;
    logic [MW-1:0]     clr_reg;
    logic [MW-1:0]     clr_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    res_t              res_reg;
    res_t              res_next;

    logic [RW-1:0]     rf_ra;
    logic [RW-1:0]     rf_rb;
    logic [DATA_W-1:0] rf_a;
    logic [DATA_W-1:0] rf_b;
    logic              rf_we;
    logic              dm_we;
    logic [MW-1:0]     dm_addr;
    logic [DATA_W-1:0] dm_wdata;
    logic [DATA_W-1:0] dm_rdata;
    logic              div_start;
    logic [DATA_W-1:0] div_a;
    logic [DATA_W-1:0] div_b;
    div_res_t          div_res;
    logic              out_free;
    logic [DATA_W-1:0] pc_inc;
    logic [DATA_W-1:0] pc_rel;

    // register number modulo NUM_REGS by shifted compare and subtract
    function automatic logic [RW-1:0] reg_mod(input logic [7:0] x);
        logic [15:0] r;
        r = {8'd0, x};
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= (16'(NUM_REGS) << k))
            begin
                r = r - (16'(NUM_REGS) << k);
            end
        end
        return r[RW-1:0];
    endfunction

    // address modulo MEM_WORDS: eight compare-and-subtract steps per group,
    // group 3 covers shifts 31..24 down to group 0 with shifts 7..0
    function automatic logic [DATA_W-1:0] addr_fold(input logic [DATA_W-1:0] x,
                                                    input logic [1:0] grp);
        logic [63:0] r;
        logic [63:0] m;
        r = {32'd0, x};
        for (int j = 7; j >= 0; j--)
        begin
            m = 64'(MEM_WORDS) << {grp, 3'(j)};
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return r[DATA_W-1:0];
    endfunction

    assign rf_ra = reg_mod({3'd0, cmd.dest_reg});
    assign rf_rb = reg_mod(cmd.operand_value[7:0]);

    rvx_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr_a (rf_ra),
        .rd_addr_b (rf_rb),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b),
        .wr_en     (rf_we),
        .wr_addr   (rd_reg),
        .wr_data   (val_reg)
    );

    rvx_dmem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dmem (
        .clk     (clk),
        .wr_en   (dm_we),
        .addr    (dm_addr),
        .wr_data (dm_wdata),
        .rd_data (dm_rdata)
    );

    rvx_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .result   (div_res)
    );

    assign out_free = !res_valid_reg || !res_stall;
    assign pc_inc   = pc_reg + 1'b1;
    assign pc_rel   = pc_reg + imm_reg;
    assign dm_addr  = (state_reg == ST_CLEAR) ? clr_reg : addr_reg;

    // sequencer: next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        rd_next        = rd_reg;
        imm_next       = imm_reg;
        a_next         = a_reg;
        val_next       = val_reg;
        wr_next        = wr_reg;
        prn_next       = prn_reg;
        dz_next        = dz_reg;
        pc_next        = pc_reg;
        npc_next       = npc_reg;
        addr_next      = addr_reg;
        fold_next      = fold_reg;
        fgrp_next      = fgrp_reg;
        clr_next       = clr_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        cmd_stall      = (state_reg != ST_IDLE);
        rf_we          = 1'b0;
        dm_we          = 1'b0;
        dm_wdata       = a_reg;
        div_start      = 1'b0;
        div_a          = rf_a;
        div_b          = rf_b;

        case (state_reg)
            ST_CLEAR:
            begin
                dm_we    = 1'b1;
                dm_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MW'(MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next    = cmd.op;
                    rd_next    = rf_ra;
                    imm_next   = cmd.operand_value;
                    state_next = ST_OPS;
                end
            end
            ST_OPS:
            begin
                a_next     = rf_a;
                val_next   = '0;
                wr_next    = 1'b1;
                prn_next   = 1'b0;
                dz_next    = 1'b0;
                npc_next   = pc_inc;
                state_next = ST_WB;
                case (op_reg)
                    OP_MOVE:  val_next = imm_reg;
                    OP_COPY:  val_next = rf_b;
                    OP_ADD:   val_next = rf_a + rf_b;
                    OP_SUB:   val_next = rf_a - rf_b;
                    OP_MUL:   val_next = DATA_W'(rf_a * rf_b);
                    OP_DIV:
                    begin
                        if (rf_b == '0)
                        begin
                            val_next = '1;
                            dz_next  = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    OP_EQ:    val_next = DATA_W'(rf_a == rf_b);
                    OP_LT:    val_next = DATA_W'(rf_a < rf_b);
                    OP_LE:    val_next = DATA_W'(rf_a <= rf_b);
                    OP_GT:    val_next = DATA_W'(rf_a > rf_b);
                    OP_GE:    val_next = DATA_W'(rf_a >= rf_b);
                    OP_LOAD, OP_STORE:
                    begin
                        wr_next = (op_reg == OP_LOAD);
                        if (MEM_POW2)
                        begin
                            addr_next  = imm_reg[MW-1:0];
                            state_next = ST_MEM;
                        end
                        else
                        begin
                            fold_next  = imm_reg;
                            fgrp_next  = 2'd3;
                            state_next = ST_ADIV;
                        end
                    end
                    OP_PRINT:
                    begin
                        val_next = rf_a;
                        wr_next  = 1'b0;
                        prn_next = 1'b1;
                    end
                    OP_JZ:
                    begin
                        wr_next = 1'b0;
                        if (rf_a == '0)
                        begin
                            npc_next = pc_rel;
                        end
                    end
                    OP_JMP:
                    begin
                        wr_next  = 1'b0;
                        npc_next = pc_rel;
                    end
                    default:  val_next = '0;
                endcase
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    val_next   = div_res.quo;
                    state_next = ST_WB;
                end
            end
            ST_ADIV:
            begin
                // one group of the address fold per cycle
                fold_next = addr_fold(fold_reg, fgrp_reg);
                fgrp_next = fgrp_reg - 1'b1;
                if (fgrp_reg == 2'd0)
                begin
                    addr_next  = fold_next[MW-1:0];
                    state_next = ST_MEM;
                end
            end
            ST_MEM:
            begin
                if (op_reg == OP_STORE)
                begin
                    dm_we      = 1'b1;
                    state_next = ST_WB;
                end
                else
                begin
                    state_next = ST_LDW;
                end
            end
            ST_LDW:
            begin
                val_next   = dm_rdata;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    rf_we                 = wr_reg;
                    pc_next               = npc_reg;
                    res_valid_next        = 1'b1;
                    res_next.next_pc      = npc_reg;
                    res_next.reg_written  = wr_reg;
                    res_next.result_value = val_reg;
                    res_next.print_valid  = prn_reg;
                    res_next.div_zero     = dz_reg;
                    state_next            = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pc_reg        <= '0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rd_reg   <= rd_next;
        imm_reg  <= imm_next;
        a_reg    <= a_next;
        val_reg  <= val_next;
        wr_reg   <= wr_next;
        prn_reg  <= prn_next;
        dz_reg   <= dz_next;
        npc_reg  <= npc_next;
        addr_reg <= addr_next;
        fold_reg <= fold_next;
        fgrp_reg <= fgrp_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
